// ----- rtl/core/balanced_ternary_stream_packer_core_assert.svh -----
// Assertion macros for the balanced ternary stream packer.
`ifndef BALANCED_TERNARY_STREAM_PACKER_CORE_ASSERT_SVH
`define BALANCED_TERNARY_STREAM_PACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BTSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BTSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BTSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/btsp_pkg.sv -----
// Shared types, constants and the scale table of the ternary packer.
package btsp_pkg;

  localparam int unsigned SAMPLE_W          = 18;
  localparam int unsigned CFG_W             = 5;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned FILL_W            = 3;
  localparam int unsigned BUF_DEPTH         = 4;
  localparam int unsigned MAX_TRITS_DEF     = 19;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd8;
  localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

  localparam logic [1:0] DIGIT_NEG  = 2'd0;
  localparam logic [1:0] DIGIT_ZERO = 2'd1;
  localparam logic [1:0] DIGIT_POS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_TRIT,
    ST_FLUSH
  } btsp_state_t;

  // (3^n - 1) / 2
  function automatic logic [31:0] scale_of(input logic [CFG_W-1:0] n);
    logic [31:0] m;
    case (n)
      5'd1:    m = 32'd1;
      5'd2:    m = 32'd4;
      5'd3:    m = 32'd13;
      5'd4:    m = 32'd40;
      5'd5:    m = 32'd121;
      5'd6:    m = 32'd364;
      5'd7:    m = 32'd1093;
      5'd8:    m = 32'd3280;
      5'd9:    m = 32'd9841;
      5'd10:   m = 32'd29524;
      5'd11:   m = 32'd88573;
      5'd12:   m = 32'd265720;
      5'd13:   m = 32'd797161;
      5'd14:   m = 32'd2391484;
      5'd15:   m = 32'd7174453;
      5'd16:   m = 32'd21523360;
      5'd17:   m = 32'd64570081;
      5'd18:   m = 32'd193710244;
      5'd19:   m = 32'd581130733;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/btsp_in_if.sv -----
// Sample request channel: valid/ready with sample and last flag.
interface btsp_in_if import btsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

// ----- rtl/core/btsp_out_if.sv -----
// Packed byte request channel: valid/ready with byte and framing flags.
interface btsp_out_if import btsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;
  logic              stream_end;

  modport source (output valid, output packed_byte, output last_of_run, output stream_end,
                  input ready);
  modport sink   (input valid, input packed_byte, input last_of_run, input stream_end,
                  output ready);
endinterface

// ----- rtl/core/btsp_trit_unit.sv -----
// Shared divide-by-three step: emits one balanced trit digit and the next quotient.
module btsp_trit_unit import btsp_pkg::*; #(
  parameter int unsigned K_W = 30
) (
  input  logic [K_W-1:0] k_i,
  input  logic           neg_i,
  output logic [K_W-1:0] k_o,
  output logic [1:0]     digit_o
);

  localparam int unsigned P_W = 2 * K_W + 1;
  localparam logic [K_W:0] RECIP = K_W'(1) == 0 ? '0 :
                                   (K_W+1)'(((64'd1 << (K_W + 1)) + 64'd2) / 64'd3);

  logic [P_W-1:0] prod;
  logic [K_W-1:0] q;
  logic [K_W+1:0] three_q;
  logic [K_W+1:0] diff;
  logic [1:0]     r;

  assign prod    = P_W'(k_i) * P_W'(RECIP);
  assign q       = prod[P_W-1:K_W+1];
  assign three_q = (K_W+2)'(q) + ((K_W+2)'(q) << 1);
  assign diff    = (K_W+2)'(k_i) - three_q;
  assign r       = diff[1:0];

  always_comb begin
    case (r)
      2'd1: begin
        digit_o = neg_i ? DIGIT_NEG : DIGIT_POS;
        k_o     = q;
      end
      2'd2: begin
        digit_o = neg_i ? DIGIT_POS : DIGIT_NEG;
        k_o     = q + K_W'(1);
      end
      default: begin
        digit_o = DIGIT_ZERO;
        k_o     = q;
      end
    endcase
  end

endmodule

// ----- rtl/core/balanced_ternary_stream_packer_core.sv -----
// Top level: samples in, scaled, split into balanced trits, packed five per byte.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   sample_value[17:0] signed, last_sample
//   out_ch   out  valid/ready   packed_byte[7:0], last_of_run, stream_end
//   cfg      in   cfg_we        cfg_wdata[4:0] = trits_per_value
//
// A sample is accepted, then scaled by a multiply, then split into trits by the
// shared divide-by-three unit, one trit per cycle unless a stall holds it; a last
// sample adds a flush state, whether or not a padded byte goes out. A trit that
// completes a byte, and the padded flush, wait while the output register is still
// held by the sink. Synchronous reset, no clearing pass.
`include "balanced_ternary_stream_packer_core_assert.svh"

module balanced_ternary_stream_packer_core import btsp_pkg::*; #(
  parameter int unsigned MAX_TRITS     = MAX_TRITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  btsp_in_if.sink          in_ch,
  btsp_out_if.source       out_ch
);

  localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_TRITS);
  localparam int unsigned K_W    = $clog2(scale_of(MAX_N) + 32'd1);
  localparam int unsigned PROD_W = SAMPLE_W + K_W;
  localparam int unsigned SUM_W  = (PROD_W > FRACTION_BITS ? PROD_W : FRACTION_BITS) + 1;
  localparam int unsigned CMP_W  = (FRACTION_BITS + 1 > SAMPLE_W) ? FRACTION_BITS + 1
                                                                   : SAMPLE_W;
  localparam logic [CMP_W-1:0] ONE  = CMP_W'(1) << FRACTION_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRACTION_BITS - 1);

  btsp_state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cfg_r;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_lor_r;
  logic                out_se_r;

  logic [SAMPLE_W-1:0] mag_r;
  logic                neg_r;
  logic                last_r;
  logic [K_W-1:0]      scale_r;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [CFG_W-1:0]    cnt_r;
  logic [1:0]          buf_r [BUF_DEPTH];

  logic                in_fire;
  logic                slot_free;
  logic                step_ok;
  logic                do_step;
  logic                emit;
  logic [BYTE_W-1:0]   emit_byte;
  logic                emit_lor;
  logic                emit_se;
  logic [CFG_W-1:0]    rem;
  logic [CFG_W-1:0]    n_sel;
  logic [SAMPLE_W-1:0] mag_raw;
  logic [SAMPLE_W-1:0] mag_cl;
  logic [PROD_W-1:0]   prod_s;
  logic [SUM_W-1:0]    sum_s;
  logic [K_W-1:0]      unit_k;
  logic [1:0]          unit_digit;
  logic [1:0]          pad [BUF_DEPTH];

  function automatic logic [BYTE_W-1:0] pack5(input logic [1:0] d0, input logic [1:0] d1,
                                              input logic [1:0] d2, input logic [1:0] d3,
                                              input logic [1:0] d4);
    return BYTE_W'(d0) + BYTE_W'(d1) * 8'd3 + BYTE_W'(d2) * 8'd9 +
           BYTE_W'(d3) * 8'd27 + BYTE_W'(d4) * 8'd81;
  endfunction

  btsp_trit_unit #(.K_W(K_W)) u_trit (
    .k_i     (k_r),
    .neg_i   (neg_r),
    .k_o     (unit_k),
    .digit_o (unit_digit)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign step_ok   = (fill_r != FILL_FULL) || slot_free;
  assign rem       = cnt_r - CFG_W'(1);

  assign mag_raw = in_ch.sample_value[SAMPLE_W-1] ? SAMPLE_W'(-in_ch.sample_value)
                                                  : SAMPLE_W'(in_ch.sample_value);
  assign mag_cl  = (CMP_W'(mag_raw) > ONE) ? SAMPLE_W'(ONE) : mag_raw;

  always_comb begin
    if (cfg_r == '0) begin
      n_sel = CFG_W'(1);
    end else if (cfg_r > MAX_N) begin
      n_sel = MAX_N;
    end else begin
      n_sel = cfg_r;
    end
  end

  assign prod_s = PROD_W'(mag_r) * PROD_W'(scale_r);
  assign sum_s  = SUM_W'(prod_s) + HALF;

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      pad[i] = (FILL_W'(i) < fill_r) ? buf_r[i] : DIGIT_ZERO;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_TRIT;
      ST_TRIT: begin
        if (step_ok && cnt_r == CFG_W'(1)) begin
          state_nxt = last_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: if (fill_r == '0 || slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    do_step     = 1'b0;
    emit        = 1'b0;
    emit_byte   = pack5(buf_r[0], buf_r[1], buf_r[2], buf_r[3], unit_digit);
    emit_lor    = !((rem >= CFG_W'(5)) || (last_r && rem != '0));
    emit_se     = last_r && rem == '0;
    fill_nxt    = fill_r;
    k_nxt       = K_W'(sum_s >> FRACTION_BITS);
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SCALE: ;
      ST_TRIT: begin
        if (step_ok) begin
          do_step = 1'b1;
          if (fill_r == FILL_FULL) begin
            emit     = 1'b1;
            fill_nxt = '0;
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        emit_byte = pack5(pad[0], pad[1], pad[2], pad[3], DIGIT_ZERO);
        emit_lor  = 1'b1;
        emit_se   = 1'b1;
        if (fill_r != '0 && slot_free) begin
          emit     = 1'b1;
          fill_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_byte = out_byte_r;
  assign out_ch.last_of_run = out_lor_r;
  assign out_ch.stream_end  = out_se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r   <= mag_cl;
      neg_r   <= in_ch.sample_value[SAMPLE_W-1];
      last_r  <= in_ch.last_sample;
      scale_r <= K_W'(scale_of(n_sel));
      cnt_r   <= n_sel;
    end
    if (state_r == ST_SCALE) begin
      k_r <= k_nxt;
    end
    if (do_step) begin
      k_r   <= unit_k;
      cnt_r <= rem;
      if (fill_r != FILL_FULL) begin
        buf_r[fill_r[1:0]] <= unit_digit;
      end
    end
    if (emit) begin
      out_byte_r <= emit_byte;
      out_lor_r  <= emit_lor;
      out_se_r   <= emit_se;
    end
  end

  `BTSP_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_r <= FILL_FULL, "fill past four")
  `BTSP_ASSERT_NXT(a_accept_scale, clk, rst_n, in_fire, state_r == ST_SCALE, "no scale step")
  `BTSP_ASSERT_IMP(a_trit_count, clk, rst_n, state_r == ST_TRIT, cnt_r != '0, "no trits left")
  `BTSP_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid_r && out_se_r, out_lor_r, "lone end")

endmodule
